### design/hcbs_pkg.sv
// Shared types and constants for the bank-switch decoder.
// No dependencies; imported by home_computer_bank_switch_decoder.
package hcbs_pkg;

    // Target codes of the memory map
    typedef enum logic [3:0] {
        TGT_RAM    = 4'd0,
        TGT_DIR    = 4'd1,
        TGT_PORT   = 4'd2,
        TGT_BASIC  = 4'd3,
        TGT_KERNEL = 4'd4,
        TGT_CHAR   = 4'd5,
        TGT_VIDEO  = 4'd6,
        TGT_SOUND  = 4'd7,
        TGT_COLOR  = 4'd8,
        TGT_TIMER1 = 4'd9,
        TGT_TIMER2 = 4'd10
    } target_t;

    localparam int ADDR_W  = 16;
    localparam int LOCAL_W = 13;
    localparam int DATA_W  = 8;

    // Processor port
    localparam logic [ADDR_W-1:0] ADDR_DIR   = 16'h0000;
    localparam logic [ADDR_W-1:0] ADDR_PORT  = 16'h0001;
    localparam logic [DATA_W-1:0] DIR_RESET  = 8'h1F;
    localparam logic [DATA_W-1:0] PORT_PULLS = 8'h17;

    // 4K pages
    localparam logic [3:0] PAGE_BASIC_LO  = 4'hA;
    localparam logic [3:0] PAGE_BASIC_HI  = 4'hB;
    localparam logic [3:0] PAGE_IO        = 4'hD;
    localparam logic [3:0] PAGE_KERNEL_LO = 4'hE;
    localparam logic [3:0] PAGE_KERNEL_HI = 4'hF;

    // I/O window ends
    localparam logic [ADDR_W-1:0] IO_VIDEO_END  = 16'hD3FF;
    localparam logic [ADDR_W-1:0] IO_SOUND_END  = 16'hD7FF;
    localparam logic [ADDR_W-1:0] IO_COLOR_END  = 16'hDBFF;
    localparam logic [ADDR_W-1:0] IO_TIMER1_END = 16'hDCFF;

    // Local address masks
    localparam logic [LOCAL_W-1:0] MASK_ROM8K = 13'h1FFF;
    localparam logic [LOCAL_W-1:0] MASK_CHAR  = 13'h0FFF;
    localparam logic [LOCAL_W-1:0] MASK_VIDEO = 13'h003F;
    localparam logic [LOCAL_W-1:0] MASK_SOUND = 13'h001F;
    localparam logic [LOCAL_W-1:0] MASK_COLOR = 13'h03FF;
    localparam logic [LOCAL_W-1:0] MASK_TIMER = 13'h000F;

    // One decoded access on its way to the output
    typedef struct packed {
        target_t             target;
        logic [LOCAL_W-1:0]  local_address;
        logic [DATA_W-1:0]   read_data;
        logic                data_valid;
        logic                device_write;
        logic [DATA_W-1:0]   device_data;
        logic                from_ram;
    } result_t;

endpackage

### design/home_computer_bank_switch_decoder.sv
// Top level of the bank-switch decoder: address decode, port registers,
// bank flags and the 64K main RAM. Depends on hcbs_pkg.

// Bank-switch decoder for a 6510-style memory map. Each input beat is one
// bus access (address, mode, write byte); each yields exactly one output
// beat with the target, the local address inside it, and read data where
// the block answers the read itself (RAM, direction and port registers).
// Throughput is one access per clock unless m_ready stalls the output;
// an access passes the synchronous RAM read stage, then the output
// register. The RAM has a single port used by at most one access per
// cycle, so a read always sees every earlier write. Writing the port data
// register changes the bank flags for the very next access. After reset
// the RAM is cleared by a sweep over all RAM_DEPTH entries (65536 by
// default), one entry per clock, during which s_ready stays low.
module home_computer_bank_switch_decoder
    import hcbs_pkg::*;
#(
    parameter int RAM_DEPTH = 65536
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ADDR_W-1:0]   s_address,
    input  logic                s_mode,
    input  logic [DATA_W-1:0]   s_write_data,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [3:0]          m_target,
    output logic [LOCAL_W-1:0]  m_local_address,
    output logic [DATA_W-1:0]   m_read_data,
    output logic                m_data_valid,
    output logic                m_device_write,
    output logic [DATA_W-1:0]   m_device_data
);

    localparam int RAM_AW = $clog2(RAM_DEPTH);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] ram_mem [RAM_DEPTH];
    logic [DATA_W-1:0] ram_q_reg;

    logic              clear_reg;
    logic [RAM_AW-1:0] clear_cnt_reg;

    logic [DATA_W-1:0] dir_reg;
    logic [DATA_W-1:0] port_reg;
    logic              basic_reg;
    logic              kernel_reg;
    logic              charset_reg;
    logic              io_reg;

    logic              s1_valid_reg;
    result_t           s1_reg;
    logic              out_valid_reg;
    result_t           out_reg;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic s1_adv;
    logic accept;

    assign s1_adv  = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !clear_reg && (!s1_valid_reg || s1_adv);
    assign accept  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Decode of the incoming access against the current flags
    // ------------------------------------------------------------------
    logic [3:0]        page;
    logic              is_basic_pg;
    logic              is_kernel_pg;
    logic              is_io_pg;
    target_t           io_tgt;
    logic [LOCAL_W-1:0] io_loc;
    logic [LOCAL_W-1:0] addr_lo;
    logic [DATA_W-1:0] port_rd;
    result_t           dec_next;
    logic              ram_wr;

    assign page         = s_address[ADDR_W-1:ADDR_W-4];
    assign is_basic_pg  = (page == PAGE_BASIC_LO) || (page == PAGE_BASIC_HI);
    assign is_kernel_pg = (page == PAGE_KERNEL_LO) || (page == PAGE_KERNEL_HI);
    assign is_io_pg     = (page == PAGE_IO);
    assign addr_lo      = s_address[LOCAL_W-1:0];
    assign port_rd      = (dir_reg & port_reg) | (~dir_reg & PORT_PULLS);

    always_comb begin
        priority if (s_address <= IO_VIDEO_END) begin
            io_tgt = TGT_VIDEO;
            io_loc = addr_lo & MASK_VIDEO;
        end else if (s_address <= IO_SOUND_END) begin
            io_tgt = TGT_SOUND;
            io_loc = addr_lo & MASK_SOUND;
        end else if (s_address <= IO_COLOR_END) begin
            io_tgt = TGT_COLOR;
            io_loc = addr_lo & MASK_COLOR;
        end else if (s_address <= IO_TIMER1_END) begin
            io_tgt = TGT_TIMER1;
            io_loc = addr_lo & MASK_TIMER;
        end else begin
            io_tgt = TGT_TIMER2;
            io_loc = addr_lo & MASK_TIMER;
        end
    end

    always_comb begin
        dec_next               = '0;
        dec_next.target        = TGT_RAM;
        dec_next.local_address = addr_lo & MASK_ROM8K;
        ram_wr                 = 1'b0;
        if (!s_mode) begin
            priority if (s_address == ADDR_DIR) begin
                dec_next.target        = TGT_DIR;
                dec_next.local_address = '0;
                dec_next.read_data     = dir_reg;
                dec_next.data_valid    = 1'b1;
            end else if (s_address == ADDR_PORT) begin
                dec_next.target        = TGT_PORT;
                dec_next.local_address = '0;
                dec_next.read_data     = port_rd;
                dec_next.data_valid    = 1'b1;
            end else if (is_basic_pg && basic_reg) begin
                dec_next.target        = TGT_BASIC;
            end else if (is_io_pg && charset_reg) begin
                dec_next.target        = TGT_CHAR;
                dec_next.local_address = addr_lo & MASK_CHAR;
            end else if (is_io_pg && io_reg) begin
                dec_next.target        = io_tgt;
                dec_next.local_address = io_loc;
            end else if (is_kernel_pg && kernel_reg) begin
                dec_next.target        = TGT_KERNEL;
            end else begin
                // RAM read, data joins from ram_q_reg when the access enters the output register
                dec_next.data_valid    = 1'b1;
                dec_next.from_ram      = 1'b1;
            end
        end else begin
            priority if (s_address == ADDR_DIR) begin
                dec_next.target        = TGT_DIR;
                dec_next.local_address = '0;
            end else if (s_address == ADDR_PORT) begin
                dec_next.target        = TGT_PORT;
                dec_next.local_address = '0;
            end else if (is_io_pg && io_reg) begin
                dec_next.target        = io_tgt;
                dec_next.local_address = io_loc;
                dec_next.device_write  = 1'b1;
                dec_next.device_data   = s_write_data;
            end else begin
                // everything else, ROM areas included, lands in RAM
                ram_wr = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main RAM: one port, shared by the clearing sweep and accesses
    // ------------------------------------------------------------------
    logic [RAM_AW-1:0] ram_addr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_we;

    assign ram_addr  = clear_reg ? clear_cnt_reg : s_address[RAM_AW-1:0];
    assign ram_wdata = clear_reg ? '0 : s_write_data;
    assign ram_we    = clear_reg || (accept && ram_wr);

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            ram_mem[ram_addr] <= ram_wdata;
        end
        if (accept) begin
            ram_q_reg <= ram_mem[ram_addr];
        end
    end

    // clearing sweep after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg     <= 1'b1;
            clear_cnt_reg <= '0;
        end else if (clear_reg) begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == RAM_AW'(RAM_DEPTH - 1)) begin
                clear_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Port registers and bank flags
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] p_next;

    assign p_next = ~dir_reg | s_write_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg     <= DIR_RESET;
            port_reg    <= '0;
            basic_reg   <= 1'b1;
            kernel_reg  <= 1'b1;
            charset_reg <= 1'b0;
            io_reg      <= 1'b1;
        end else if (accept && s_mode) begin
            if (s_address == ADDR_DIR) begin
                dir_reg <= s_write_data;
            end else if (s_address == ADDR_PORT) begin
                port_reg    <= s_write_data;
                basic_reg   <= (p_next[1:0] == 2'b11);
                kernel_reg  <= p_next[1];
                charset_reg <= (p_next[1:0] != 2'b00) && !p_next[2];
                io_reg      <= (p_next[1:0] != 2'b00) && p_next[2];
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline: RAM read stage, then output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= dec_next;
        end
        if (s1_adv) begin
            out_reg <= s1_reg;
            if (s1_reg.from_ram) begin
                out_reg.read_data <= ram_q_reg;
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_target        = out_reg.target;
    assign m_local_address = out_reg.local_address;
    assign m_read_data     = out_reg.read_data;
    assign m_data_valid    = out_reg.data_valid;
    assign m_device_write  = out_reg.device_write;
    assign m_device_data   = out_reg.device_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_reg |-> !s_ready)
        else $error("access accepted during RAM clearing");

    a_dir_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode && (s_address == ADDR_DIR)) |=> (dir_reg == $past(s_write_data)))
        else $error("direction write not stored");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(charset_reg && io_reg))
        else $error("character ROM and I/O visible together");

    a_out_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data_valid && m_device_write))
        else $error("result both read locally and forwarded as device write");

endmodule
